>>> design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and the arctangent table of the polar/rectangular
// CORDIC converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int DATA_WIDTH_DEF = 24;
  localparam int TABLE_LEN      = 24;

  localparam int FW = 24;   // field width of every coordinate on the ports
  localparam int XW = 36;   // CORDIC x/y datapath, Q.16
  localparam int ZW = 32;   // CORDIC angle datapath, degrees Q.20

  localparam logic [24:0] MOD_OFFSET = 25'd8524800;   // 180 deg + 92 turns, Q8
  localparam logic [14:0] RECIP_45   = 15'd23302;     // ceil(2^20 / 45)
  localparam logic [5:0]  TURN_HI    = 6'd45;         // 360 deg Q8 = 45 << 11

  localparam logic signed [17:0] DEG_Q8_180  = 18'sd46080;
  localparam logic signed [ZW-1:0] DEG_Q20_90  = 32'sd94371840;
  localparam logic signed [ZW-1:0] DEG_Q20_180 = 32'sd188743680;
  localparam logic signed [24:0] GAIN_Q24    = 25'sd10188014;

  typedef enum logic {
    CMD_P2R = 1'b0,
    CMD_R2P = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic                  zero;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

  localparam logic [ZW-1:0] ATAN_TBL [TABLE_LEN] = '{
    32'd47185920, 32'd27855475, 32'd14718068, 32'd7471121,
    32'd3750058,  32'd1876857,  32'd938658,   32'd469357,
    32'd234682,   32'd117342,   32'd58671,    32'd29335,
    32'd14668,    32'd7334,     32'd3667,     32'd1833,
    32'd917,      32'd458,      32'd229,      32'd115,
    32'd57,       32'd29,       32'd14,       32'd7
  };

  // atan(2^-idx) in degrees Q.20
  function automatic logic signed [ZW-1:0] atan_deg(logic [4:0] idx);
    return $signed(ATAN_TBL[idx]);
  endfunction

endpackage

>>> design/prc_in_if.sv
// ----------------------------------------------------------------------------
// prc_in_if
// Input channel: command and one coordinate pair, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_in_if
  import prc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic signed [FW-1:0] first_value;
  logic signed [FW-1:0] second_value;

  modport source (output valid, command, first_value, second_value, input ready);
  modport sink   (input valid, command, first_value, second_value, output ready);
endinterface

>>> design/prc_out_if.sv
// ----------------------------------------------------------------------------
// prc_out_if
// Result channel: converted pair and saturation flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_out_if
  import prc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] first_result;
  logic signed [FW-1:0] second_result;
  logic                 saturated;

  modport source (output valid, first_result, second_result, saturated, input ready);
  modport sink   (input valid, first_result, second_result, saturated, output ready);
endinterface

>>> design/polar_rect_converter.sv
// ----------------------------------------------------------------------------
// polar_rect_converter
// Pipelined CORDIC converting polar <-> rectangular, Q16.8 in and out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    command, first_value, second_value
//  out_ch   out  valid/ready    first_result, second_result, saturated
//
//  One pair per cycle sustained while out_ch is not stalled. Stages: angle
//  reduction (3 stages), one stage per CORDIC iteration, gain and rounding (3).
//  Synchronous active-low reset clears the stage valid bits only.
//  Each stage holds while the one after it is full and stalled; empty stages
//  fill behind a stalled output, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module polar_rect_converter
  import prc_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prc_in_if.sink     in_ch,
  prc_out_if.source  out_ch
);

  localparam int NS = ITERATIONS + 6;
  localparam int GS = ITERATIONS + 3;   // first gain stage
  localparam int PW = XW + 25;          // gain product width
  localparam int GW = PW - 24;          // after the 2^-24 step
  localparam int AW = ZW - 12;          // angle in Q.8
  localparam int CW = 40;               // clip compare width
  localparam logic signed [CW-1:0] LIM_HI = (CW'(1) <<< (DATA_WIDTH - 1)) - CW'(1);
  localparam logic signed [CW-1:0] LIM_LO = -LIM_HI - CW'(1);

  // ---------------- stage control ----------------
  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  assign rdy[NS] = out_ch.ready;
  assign vin     = {vld_r[NS-2:0], in_ch.valid};

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !vld_r[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) vld_r[i] <= vin[i];
      end
    end
  end

  assign in_ch.ready = rdy[0];

  // ---------------- stage 0: offset angle to a positive value ----------------
  logic [24:0]          ang_u;
  cmd_t                 p0_cmd_r;
  logic signed [FW-1:0] p0_a_r, p0_b_r;
  logic [13:0]          p0_w_r;
  logic [10:0]          p0_lo_r;

  assign ang_u = 25'($signed(in_ch.second_value)) + MOD_OFFSET;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0_cmd_r <= in_ch.command;
      p0_a_r   <= in_ch.first_value;
      p0_b_r   <= in_ch.second_value;
      p0_w_r   <= ang_u[24:11];
      p0_lo_r  <= ang_u[10:0];
    end
  end

  // ---------------- stage 1: whole turns by reciprocal multiply ----------------
  logic [28:0]          quo_prod;
  cmd_t                 p1_cmd_r;
  logic signed [FW-1:0] p1_a_r, p1_b_r;
  logic [13:0]          p1_w_r;
  logic [10:0]          p1_lo_r;
  logic [7:0]           p1_q_r;

  // 360 deg Q8 = 45 * 2^11, so the low 11 bits pass and w mod 45 remains
  assign quo_prod = 29'(p0_w_r) * 29'(RECIP_45);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1_cmd_r <= p0_cmd_r;
      p1_a_r   <= p0_a_r;
      p1_b_r   <= p0_b_r;
      p1_w_r   <= p0_w_r;
      p1_lo_r  <= p0_lo_r;
      p1_q_r   <= quo_prod[27:20];
    end
  end

  // ---------------- stage 2: remainder, quadrant fold, CORDIC seed ----------------
  logic [13:0]          turn_sub;
  logic [13:0]          rem_w;
  logic signed [17:0]   ang_q8;
  logic signed [ZW-1:0] ang_q20;
  logic signed [XW-1:0] xa, yb;
  cordic_t              seed;

  cordic_t cr_r [ITERATIONS+1];

  assign turn_sub = 14'(p1_q_r) * 14'(TURN_HI);
  assign rem_w    = p1_w_r - turn_sub;
  assign ang_q8   = $signed({1'b0, rem_w[5:0], p1_lo_r}) - DEG_Q8_180;
  assign ang_q20  = ZW'(ang_q8) <<< 12;
  assign xa       = XW'(p1_a_r) <<< 8;
  assign yb       = XW'(p1_b_r) <<< 8;

  always_comb begin
    seed.cmd  = p1_cmd_r;
    seed.zero = 1'b0;
    seed.x    = xa;
    seed.y    = '0;
    seed.z    = ang_q20;
    if (p1_cmd_r == CMD_P2R) begin
      if (ang_q20 > DEG_Q20_90) begin
        seed.x = -xa;
        seed.z = ang_q20 - DEG_Q20_180;
      end else if (ang_q20 < -DEG_Q20_90) begin
        seed.x = -xa;
        seed.z = ang_q20 + DEG_Q20_180;
      end
    end else begin
      seed.zero = (p1_a_r == '0) && (p1_b_r == '0);
      seed.y    = yb;
      seed.z    = '0;
      if (xa < 0) begin
        seed.x = -xa;
        seed.y = -yb;
        seed.z = p1_b_r[FW-1] ? -DEG_Q20_180 : DEG_Q20_180;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) cr_r[0] <= seed;
  end

  // ---------------- CORDIC iterations, one per stage ----------------
  genvar j;
  generate
    for (j = 0; j < ITERATIONS; j++) begin : g_iter
      logic signed [XW-1:0] xi, yi, dx, dy;
      logic signed [ZW-1:0] zi, at;
      logic                 dir;
      cordic_t              nxt;

      assign xi  = cr_r[j].x;
      assign yi  = cr_r[j].y;
      assign zi  = cr_r[j].z;
      assign dx  = yi >>> j;
      assign dy  = xi >>> j;
      assign at  = atan_deg(5'(j));
      // rotation drives z to zero, vectoring drives y to zero
      assign dir = (cr_r[j].cmd == CMD_R2P) ? yi[XW-1] : !zi[ZW-1];

      always_comb begin
        nxt = cr_r[j];
        if (dir) begin
          nxt.x = xi - dx;
          nxt.y = yi + dy;
          nxt.z = zi - at;
        end else begin
          nxt.x = xi + dx;
          nxt.y = yi - dy;
          nxt.z = zi + at;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[3+j]) cr_r[j+1] <= nxt;
      end
    end
  endgenerate

  // ---------------- gain stage 1: partial products ----------------
  cordic_t              fin;
  logic signed [17:0]   xh, yh;
  logic signed [18:0]   xl, yl;
  cmd_t                 g1_cmd_r;
  logic                 g1_zero_r;
  logic signed [ZW-1:0] g1_z_r;
  logic signed [42:0]   g1_xh_r, g1_yh_r;
  logic signed [43:0]   g1_xl_r, g1_yl_r;

  assign fin = cr_r[ITERATIONS];
  assign xh  = fin.x[XW-1:18];
  assign yh  = fin.y[XW-1:18];
  assign xl  = $signed({1'b0, fin.x[17:0]});
  assign yl  = $signed({1'b0, fin.y[17:0]});

  always_ff @(posedge clk) begin
    if (rdy[GS]) begin
      g1_cmd_r  <= fin.cmd;
      g1_zero_r <= fin.zero;
      g1_z_r    <= fin.z;
      g1_xh_r   <= xh * GAIN_Q24;
      g1_yh_r   <= yh * GAIN_Q24;
      g1_xl_r   <= xl * GAIN_Q24;
      g1_yl_r   <= yl * GAIN_Q24;
    end
  end

  // ---------------- gain stage 2: sum and round at 2^-24 ----------------
  logic signed [PW-1:0] xsum, ysum;
  logic signed [ZW-1:0] zsum;
  cmd_t                 g2_cmd_r;
  logic                 g2_zero_r;
  logic signed [GW-1:0] g2_x_r, g2_y_r;
  logic signed [AW-1:0] g2_ang_r;

  assign xsum = (PW'(g1_xh_r) <<< 18) + PW'(g1_xl_r) + (PW'(1) <<< 23);
  assign ysum = (PW'(g1_yh_r) <<< 18) + PW'(g1_yl_r) + (PW'(1) <<< 23);
  assign zsum = g1_z_r + ZW'(2048);

  always_ff @(posedge clk) begin
    if (rdy[GS+1]) begin
      g2_cmd_r  <= g1_cmd_r;
      g2_zero_r <= g1_zero_r;
      g2_x_r    <= xsum[PW-1:24];
      g2_y_r    <= ysum[PW-1:24];
      g2_ang_r  <= zsum[ZW-1:12];
    end
  end

  // ---------------- output stage: round to Q.8 and clip ----------------
  logic signed [GW-1:0] xr_sum, yr_sum;
  logic signed [CW-1:0] xr, yr, xc, yc;
  logic                 xs, ys;
  logic signed [AW-1:0] ang_c;
  logic signed [FW-1:0] res0, res1;
  logic                 res_sat;
  logic signed [FW-1:0] out_first_r, out_second_r;
  logic                 out_sat_r;

  assign xr_sum = g2_x_r + GW'(128);
  assign yr_sum = g2_y_r + GW'(128);
  // part-selects are unsigned, re-sign before widening
  assign xr     = CW'($signed(xr_sum[GW-1:8]));
  assign yr     = CW'($signed(yr_sum[GW-1:8]));

  always_comb begin
    xc = xr;
    xs = 1'b0;
    if (xr > LIM_HI) begin
      xc = LIM_HI;
      xs = 1'b1;
    end else if (xr < LIM_LO) begin
      xc = LIM_LO;
      xs = 1'b1;
    end
    yc = yr;
    ys = 1'b0;
    if (yr > LIM_HI) begin
      yc = LIM_HI;
      ys = 1'b1;
    end else if (yr < LIM_LO) begin
      yc = LIM_LO;
      ys = 1'b1;
    end
    ang_c = g2_ang_r;
    if (g2_ang_r > AW'(DEG_Q8_180))       ang_c = AW'(DEG_Q8_180);
    else if (g2_ang_r < -AW'(DEG_Q8_180)) ang_c = -AW'(DEG_Q8_180);

    unique case (g2_cmd_r)
      CMD_P2R: begin
        res0    = xc[FW-1:0];
        res1    = yc[FW-1:0];
        res_sat = xs || ys;
      end
      CMD_R2P: begin
        res0    = g2_zero_r ? '0 : xc[FW-1:0];
        res1    = g2_zero_r ? '0 : FW'(ang_c);
        res_sat = !g2_zero_r && xs;
      end
      default: begin
        res0    = '0;
        res1    = '0;
        res_sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_first_r  <= res0;
      out_second_r <= res1;
      out_sat_r    <= res_sat;
    end
  end

  assign out_ch.valid         = vld_r[NS-1];
  assign out_ch.first_result  = out_first_r;
  assign out_ch.second_result = out_second_r;
  assign out_ch.saturated     = out_sat_r;

endmodule

>>> design/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the converter: occupancy, stall hold, saturation.
// ----------------------------------------------------------------------------
module prc_checker
  import prc_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [FW-1:0] first_result,
  input logic signed [FW-1:0] second_result,
  input logic                 saturated
);

  localparam int DEPTH = ITERATIONS + 6;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int CW    = 40;
  localparam logic [CW-1:0] LIM_HI = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);
  localparam logic [CW-1:0] LIM_LO = ~LIM_HI;
  localparam logic [FW-1:0] HI_FW  = LIM_HI[FW-1:0];
  localparam logic [FW-1:0] LO_FW  = LIM_LO[FW-1:0];

  logic            in_xfer, out_xfer;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer)      cnt_nxt = cnt_r + CNTW'(1);
    else if (!in_xfer && out_xfer) cnt_nxt = cnt_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_result)
      && $stable(second_result) && $stable(saturated))
    else $error("result changed or dropped during stall");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result presented with no pair in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(DEPTH))
    else $error("more pairs in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> in_ready)
    else $error("empty pipeline refuses input");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> first_result == HI_FW || first_result == LO_FW
      || second_result == HI_FW || second_result == LO_FW)
    else $error("saturated flag without a clipped result");

endmodule

bind polar_rect_converter prc_checker #(
  .ITERATIONS (ITERATIONS),
  .DATA_WIDTH (DATA_WIDTH)
) u_prc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .first_result  (out_ch.first_result),
  .second_result (out_ch.second_result),
  .saturated     (out_ch.saturated)
);
